// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the filter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rmf_pkg.sv =====
// Shared types for the running median filter.
package rmf_pkg;

	// Flags one cell hands to the next one up the sorted row.
	typedef struct packed {
		logic present;    // entry left here after removal exists
		logic not_above;  // that entry is not greater than the new sample
	} rmf_tag_t;

endpackage

// ===== hw/rtl/rmf_cell.sv =====
// One cell of the filter row: one sorted entry and one arrival entry.
module rmf_cell #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic signed [SAMPLE_WIDTH-1:0] fresh,
	input  logic signed [SAMPLE_WIDTH-1:0] stale,
	input  logic signed [SAMPLE_WIDTH-1:0] arr_in,
	output logic signed [SAMPLE_WIDTH-1:0] arr_o,
	input  logic signed [SAMPLE_WIDTH-1:0] next_val,
	input  logic                           next_present,
	input  logic signed [SAMPLE_WIDTH-1:0] prev_t,
	input  rmf_pkg::rmf_tag_t              prev_tag,
	output logic signed [SAMPLE_WIDTH-1:0] t_o,
	output rmf_pkg::rmf_tag_t              tag_o,
	output logic signed [SAMPLE_WIDTH-1:0] val_o,
	output logic signed [SAMPLE_WIDTH-1:0] upd_o
);
	import rmf_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0] val_q;
	logic signed [SAMPLE_WIDTH-1:0] arr_q;
	logic                           below;

	// Removal: entries below the departing value stay, the rest close up.
	assign below         = val_q < stale;
	assign t_o           = below ? val_q : next_val;
	assign tag_o.present = below | next_present;
	assign tag_o.not_above = tag_o.present && (t_o <= fresh);

	// Insertion after every entry not greater than the new sample.
	always_comb begin
		if (tag_o.not_above) begin
			upd_o = t_o;
		end else if (prev_tag.not_above || !prev_tag.present) begin
			upd_o = fresh;
		end else begin
			upd_o = prev_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			arr_q <= '0;
		end else if (adv) begin
			val_q <= upd_o;
			arr_q <= arr_in;
		end
	end

	assign val_o = val_q;
	assign arr_o = arr_q;

endmodule

// ===== hw/rtl/running_median_filter.sv =====
// Top level of the running median filter: a row of sort cells and an output register.
// Sliding-window median of signed samples. Every accepted sample beat produces one median
// beat: the middle entry (index WINDOW_LENGTH/2, the upper median for an even window) of
// the last WINDOW_LENGTH samples. After reset the window holds zeros, and those zeros count
// as samples until the window has filled. The design is a row of WINDOW_LENGTH identical
// cells; cell k holds the k-th smallest value and the k-th newest sample. On each accepted
// beat the row drops the departing (oldest) value: each cell at or above it takes its upper
// neighbour's entry, then opens a gap for the new sample after all entries not greater than
// it. The result lands in an output register in the cycle after acceptance. Throughput is one
// sample per clock: a new beat is taken whenever the output register is empty or is being
// drained in the same cycle.
module running_median_filter #(
	parameter int WINDOW_LENGTH = 5,
	parameter int SAMPLE_WIDTH  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] median
);
	import rmf_pkg::*;

	`include "assert_macros.svh"

	localparam int MID = WINDOW_LENGTH / 2;

	logic                           accept;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] median_q;

	// Per-cell links of the row.
	logic signed [SAMPLE_WIDTH-1:0] arr_w   [WINDOW_LENGTH];
	logic signed [SAMPLE_WIDTH-1:0] val_w   [WINDOW_LENGTH];
	logic signed [SAMPLE_WIDTH-1:0] t_w     [WINDOW_LENGTH];
	logic signed [SAMPLE_WIDTH-1:0] upd_w   [WINDOW_LENGTH];
	rmf_tag_t                       tag_w   [WINDOW_LENGTH];
	logic signed [SAMPLE_WIDTH-1:0] stale;

	// Take a beat when the output register is free or drains this cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// The newest sample sits in cell 0; the oldest leaves from the top cell.
	assign stale = arr_w[WINDOW_LENGTH-1];

	for (genvar k = 0; k < WINDOW_LENGTH; k++) begin : g_cell
		logic signed [SAMPLE_WIDTH-1:0] arr_in;
		logic signed [SAMPLE_WIDTH-1:0] next_val;
		logic                           next_present;
		logic signed [SAMPLE_WIDTH-1:0] prev_t;
		rmf_tag_t                       prev_tag;

		if (k == 0) begin : g_head
			// Bottom cell: nothing below, so the new sample may go here.
			assign arr_in           = sample;
			assign prev_t           = sample;
			assign prev_tag.present = 1'b0;
			assign prev_tag.not_above = 1'b1;
		end else begin : g_body
			assign arr_in   = arr_w[k-1];
			assign prev_t   = t_w[k-1];
			assign prev_tag = tag_w[k-1];
		end

		if (k == WINDOW_LENGTH - 1) begin : g_tail
			// Top cell: no entry above to close up the gap.
			assign next_val     = val_w[k];
			assign next_present = 1'b0;
		end else begin : g_inner
			assign next_val     = val_w[k+1];
			assign next_present = 1'b1;
		end

		rmf_cell #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (accept),
			.fresh       (sample),
			.stale       (stale),
			.arr_in      (arr_in),
			.arr_o       (arr_w[k]),
			.next_val    (next_val),
			.next_present(next_present),
			.prev_t      (prev_t),
			.prev_tag    (prev_tag),
			.t_o         (t_w[k]),
			.tag_o       (tag_w[k]),
			.val_o       (val_w[k]),
			.upd_o       (upd_w[k])
		);
	end

	// Output register: hold the median until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			median_q <= upd_w[MID];
		end
	end

	assign out_valid = out_valid_q;
	assign median    = median_q;

	// The sorted row must stay in ascending order.
	for (genvar k = 0; k < WINDOW_LENGTH - 1; k++) begin : g_chk
		`ASSERT_CLK(a_row_sorted, val_w[k] <= val_w[k+1], "sorted row out of order")
	end

	// Every accepted beat leaves a result waiting in the next cycle.
	`ASSERT_CLK(a_accept_gives_result, accept |=> out_valid, "accepted beat without result")

	// No result is offered while reset is applied.
	`ASSERT_ANY(a_reset_quiet, !arst_n |-> !out_valid, "result offered in reset")

endmodule

// ===== tb/sv/running_median_filter_tb.sv =====
// Self-checking testbench for the running median filter, with its own model of the window.
module running_median_filter_tb;

	localparam int WIN = 5;
	localparam int SW  = 16;

	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [SW-1:0] sample;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [SW-1:0] median;

	running_median_filter #(
		.WINDOW_LENGTH(WIN),
		.SAMPLE_WIDTH (SW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.median   (median)
	);

	// Window model: samples in arrival order, the same values kept ascending,
	// and the slot holding the oldest sample. All of it starts at zero, as the
	// block does after reset.
	logic signed [SW-1:0] arrival_win [WIN];
	logic signed [SW-1:0] sorted_win  [WIN];
	int                   oldest_slot;

	// Medians predicted for accepted sample beats, oldest first.
	logic signed [SW-1:0] pending_medians [$];

	int mismatch_count;

	// Sender burst state: beats left in the current burst, and a switch that
	// suppresses the gaps between bursts for a stretch of back-to-back traffic.
	int unsigned burst_left;
	bit          steady_flow;

	initial begin : clock_gen
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Advance the window model by one sample and return the new median.
	function automatic logic signed [SW-1:0] predict_median(input logic signed [SW-1:0] fresh);
		logic signed [SW-1:0] stale;
		int k;
		stale = arrival_win[oldest_slot];
		arrival_win[oldest_slot] = fresh;
		oldest_slot = (oldest_slot == WIN - 1) ? 0 : oldest_slot + 1;
		// Drop the first sorted entry equal to the departing sample; if none
		// matches, nothing moves and the insertion below pushes out the largest.
		k = 0;
		while (k < WIN && sorted_win[k] != stale)
			k++;
		while (k < WIN - 1) begin
			sorted_win[k] = sorted_win[k + 1];
			k++;
		end
		// Insert after every entry not greater than the new sample.
		k = WIN - 2;
		while (k >= 0 && sorted_win[k] > fresh) begin
			sorted_win[k + 1] = sorted_win[k];
			k--;
		end
		sorted_win[k + 1] = fresh;
		return sorted_win[WIN / 2];
	endfunction

	// Offer one sample beat and hold it until the block takes it. A new burst
	// may open with a gap of idle cycles. Entered and left at a falling edge.
	task automatic send_sample(input logic signed [SW-1:0] value);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = steady_flow ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		sample   <= value;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Receiver: out_ready follows a rotating stall mask, renewed whenever its hold
	// counter runs out. Some masks are all ones, giving stretches with no back-pressure.
	initial begin : drain_side
		logic [7:0]  stall_mask;
		int unsigned hold;
		out_ready  = 1'b0;
		stall_mask = 8'hff;
		hold       = 0;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				hold = $urandom_range(16, 80);
				if ($urandom_range(0, 3) == 0)
					stall_mask = 8'hff;
				else
					stall_mask = 8'($urandom_range(1, 255));
			end
			hold--;
			out_ready  <= stall_mask[0];
			stall_mask = {stall_mask[0], stall_mask[7:1]};
		end
	end

	// Scoreboard, sampled at the rising edge. Record an accepted sample beat
	// before checking an output beat, so the queue never runs dry by ordering.
	always @(posedge clk) begin : scoreboard
		logic signed [SW-1:0] want;
		if (arst_n) begin
			if (in_valid && in_ready)
				pending_medians.push_back(predict_median(sample));
			if (out_valid && out_ready) begin
				if (pending_medians.size() == 0) begin
					$error("median: unexpected beat, actual %0d", median);
					mismatch_count++;
				end else begin
					want = pending_medians.pop_front();
					if (median !== want) begin
						$error("median: expected %0d, actual %0d", want, median);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Start-up window: the reset zeros still sit in the window and pull the median.
	task automatic test_startup_window();
		send_sample(300);
		send_sample(-300);
		send_sample(12345);
		send_sample(-20000);
	endtask

	// Full-scale values, alternating and repeated, plus the values around zero.
	task automatic test_extremes();
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(-1);
		send_sample(1);
		send_sample(0);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
	endtask

	// Equal values: removal must take the first match, insertion goes after all matches.
	task automatic test_equal_runs();
		send_sample(7);
		send_sample(7);
		send_sample(7);
		send_sample(-2);
		send_sample(7);
		send_sample(-2);
		send_sample(-2);
		send_sample(-2);
		send_sample(7);
		send_sample(7);
	endtask

	// Uniform over the full range, so every sample bit takes both values.
	task automatic test_random_full_range(input int count);
		logic [SW-1:0] raw;
		repeat (count) begin
			raw = SW'($urandom);
			send_sample(raw);
		end
	endtask

	// A narrow band around zero: the window is full of duplicates most of the time.
	task automatic test_clustered_values(input int count);
		int v;
		repeat (count) begin
			v = $urandom_range(0, 8);
			send_sample(SW'(v - 4));
		end
	endtask

	// Rising, falling and flat runs, sent back to back; wrap-around gives big jumps.
	task automatic test_ramps_and_steps(input int count);
		logic signed [SW-1:0] level;
		int                   stride;
		int                   run;
		int                   sent;
		steady_flow = 1'b1;
		sent = 0;
		while (sent < count) begin
			level  = SW'($urandom);
			stride = $urandom_range(0, 40);
			stride = stride - 20;
			run    = $urandom_range(8, 30);
			while (run > 0 && sent < count) begin
				send_sample(level);
				level = level + SW'(stride);
				run--;
				sent++;
			end
		end
		steady_flow = 1'b0;
	endtask

	// Extremes, zero, minus one, small and arbitrary values in random order.
	task automatic test_mixed_with_extremes(input int count);
		logic [SW-1:0] raw;
		int            v;
		repeat (count) begin
			raw = SW'($urandom);
			v   = $urandom_range(0, 6) - 3;
			case ($urandom_range(0, 5))
				0: send_sample(SAMPLE_MIN);
				1: send_sample(SAMPLE_MAX);
				2: send_sample(0);
				3: send_sample(-1);
				4: send_sample(SW'(v));
				default: send_sample(raw);
			endcase
		end
	endtask

	initial begin : sequencer
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		sample         = '0;
		mismatch_count = 0;
		burst_left     = 0;
		steady_flow    = 1'b0;
		oldest_slot    = 0;
		for (int i = 0; i < WIN; i++) begin
			arrival_win[i] = '0;
			sorted_win[i]  = '0;
		end

		// Hold reset, then release it on a falling edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_startup_window();
		test_extremes();
		test_equal_runs();
		test_random_full_range(300);
		test_clustered_values(300);
		test_ramps_and_steps(200);
		test_mixed_with_extremes(150);

		// Drop valid, wait for every predicted median, then let the pipe settle.
		in_valid <= 1'b0;
		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (mismatch_count == 0)
			$display("running_median_filter: match");
		else
			$display("running_median_filter: mismatch");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run with the longest gaps and stalls.
	initial begin : watchdog
		#2000000;
		$display("running_median_filter: mismatch");
		$finish;
	end

endmodule
